### src/pcip_pkg.sv
// Package for the per-context interval profiler: sizes, codes and shared types.
// No dependencies; imported by every module of the block.
package pcip_pkg;

   localparam int NUM_REGIONS      = 512;
   localparam int SLOTS_PER_REGION = 32;
   localparam int REGION_W         = 9;
   localparam int SLOT_W           = 5;
   localparam int SLOT_ENTRIES     = NUM_REGIONS * SLOTS_PER_REGION;
   localparam int SLOT_ADDR_W      = REGION_W + SLOT_W;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_STOP  = 2'd1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_REG   = 3'd1;
   localparam logic [2:0] ST_START_RUN = 3'd2;
   localparam logic [2:0] ST_STOP_IDLE = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic [0:0] REG_REGIONS = 1'd0;

   // Statistics row of one region.
   typedef struct packed {
      logic [SLOT_W-1:0] highest;
      logic [31:0]       starts;
      logic [31:0]       stops;
      logic [63:0]       total;
      logic [63:0]       shortest;
      logic [63:0]       longest;
      logic              error;
   } region_row_type;

   // One slot entry.
   typedef struct packed {
      logic [15:0] owner;
      logic        running;
      logic [63:0] start_time;
   } slot_row_type;

   // Request to the divider and its result.
   typedef struct packed {
      logic        go;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

### src/pcip_divider.sv
// Radix-2 restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Depends on pcip_pkg.
module pcip_divider
   import pcip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic [6:0]  count_ff, count_in;
   logic [63:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] divisor_ff, divisor_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      trial      = {rem_ff, quot_ff[63]} - {1'b0, divisor_ff};
      if (req.go) begin
         busy_in    = (req.divisor != 32'd0);
         done_in    = (req.divisor == 32'd0);
         count_in   = 7'd0;
         quot_in    = (req.divisor == 32'd0) ? 64'd0 : req.dividend;
         rem_in     = 32'd0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so 32 bits hold it.
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quot_ff[63]};
            quot_in = {quot_ff[62:0], 1'b0};
         end
         count_in = count_ff + 7'd1;
         if (count_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

### src/per_context_interval_profiler.sv
// Top level of the per-context interval profiler: sequencer, slot and region memories.
// Depends on pcip_pkg and pcip_divider.
//
//  Port group  | Direction | Contents
//  req_*       | in        | event item: mode, region_id, thread_id, timestamp
//  rsp_*       | out       | result item: status, slot, duration and statistics
//  csr_*       | in/out    | APB register port, regions_registered at address 0
//
// An item is accepted and its region row is read; a start or stop then examines the
// region's slots in turn (up to 32, one slot memory read each); an update step writes
// the region row back, and the slot row for a start or stop, and starts the average
// divider, which skips the division when no interval has completed; an output step
// loads the result. A rejected region goes straight to the output step. The single-port
// slot memory and the divider set the length of an item. One item is in flight at a
// time; the result register holds it until taken, and the next item is accepted
// meanwhile. After reset a clearing pass (one slot and one region row per step, the
// region rows being rewritten as the address wraps) runs while no item is accepted.
module per_context_interval_profiler
   import pcip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] mode, [10:2] region_id, [26:11] thread_id, [90:27] timestamp
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] status, [7:3] slot, [71:8] duration, [103:72] starts_seen,
   // [135:104] stops_done, [199:136] total_time, [263:200] shortest,
   // [327:264] longest, [391:328] average, [392] error_seen
   output logic [399:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_RROW  = 9'b000000100,
      S_SCAN  = 9'b000001000,
      S_SLOT  = 9'b000010000,
      S_EXEC  = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_OUT   = 9'b010000000,
      S_WAIT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [9:0] regions_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_REGIONS) ? {22'd0, regions_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) regions_ff <= 10'd0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_REGIONS)
         regions_ff <= csr_pwdata[9:0];
   end

   // Memories
   region_row_type region_mem [NUM_REGIONS];
   slot_row_type   slot_mem   [SLOT_ENTRIES];
   region_row_type region_rd_ff;
   slot_row_type   slot_rd_ff;
   logic                   region_we, slot_we;
   logic [REGION_W-1:0]    region_addr;
   logic [SLOT_ADDR_W-1:0] slot_addr;
   region_row_type         region_wd;
   slot_row_type           slot_wd;

   always_ff @(posedge clock) begin
      if (region_we) region_mem[region_addr] <= region_wd;
      region_rd_ff <= region_mem[region_addr];
   end
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_addr] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_addr];
   end

   // Item registers
   logic [1:0]          mode_ff;
   logic [REGION_W-1:0] region_ff;
   logic [15:0]         tid_ff;
   logic [63:0]         ts_ff;
   logic [SLOT_ADDR_W-1:0] clr_ff, clr_in;
   logic [SLOT_W:0]     idx_ff, idx_in;      // scan index, one wider to hold 32
   logic [SLOT_W-1:0]   idle_ff, idle_in;
   logic                idle_ok_ff, idle_ok_in;
   logic [SLOT_W-1:0]   sel_ff, sel_in;
   logic                own_ff, own_in;      // owner must be written
   logic                full_ff, full_in;
   logic                open_ff, open_in;    // new slot opened
   region_row_type      row_ff, row_in;
   logic [2:0]          status_ff, status_in;
   logic [63:0]         dur_ff, dur_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [399:0]        rsp_data_ff, rsp_data_in;

   div_req_type dreq;
   div_rsp_type drsp;
   pcip_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [63:0] diff;
   logic [SLOT_W:0] top_ext;
   assign diff    = ts_ff - slot_rd_ff.start_time;
   assign top_ext = {1'b0, row_ff.highest};

   assign req_tready = (state_ff == S_IDLE);
   logic accept;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      idle_in      = idle_ff;
      idle_ok_in   = idle_ok_ff;
      sel_in       = sel_ff;
      own_in       = own_ff;
      full_in      = full_ff;
      open_in      = open_ff;
      row_in       = row_ff;
      status_in    = status_ff;
      dur_in       = dur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      region_we    = 1'b0;
      slot_we      = 1'b0;
      region_addr  = region_ff;
      slot_addr    = {region_ff, idx_ff[SLOT_W-1:0]};
      region_wd    = row_ff;
      slot_wd      = slot_rd_ff;
      dreq.go       = 1'b0;
      dreq.dividend = row_ff.total;
      dreq.divisor  = row_ff.stops;
      unique case (state_ff)
         S_CLEAR: begin
            slot_we   = 1'b1;
            slot_addr = clr_ff;
            slot_wd   = '0;
            region_we = 1'b1;
            region_addr = clr_ff[REGION_W-1:0];
            region_wd = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == SLOT_ADDR_W'(SLOT_ENTRIES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            region_addr = req_tdata[10:2];
            if (accept) begin
               if ({1'b0, req_tdata[10:2]} >= regions_ff) begin
                  state_in     = S_WAIT;
               end else begin
                  state_in = S_RROW;
               end
               idx_in     = '0;
               idle_ok_in = 1'b0;
               own_in     = 1'b0;
               full_in    = 1'b0;
               open_in    = 1'b0;
               sel_in     = '0;
               status_in  = ST_OK;
               dur_in     = '0;
            end
         end
         S_RROW: begin
            row_in = region_rd_ff;
            if (mode_ff == MODE_START || mode_ff == MODE_STOP) state_in = S_SCAN;
            else state_in = S_EXEC;
         end
         S_SCAN: begin
            // slot idx_ff being read this cycle; result next cycle
            state_in = S_SLOT;
         end
         S_SLOT: begin
            state_in = S_SCAN;
            if (slot_rd_ff.owner == tid_ff) begin
               sel_in = idx_ff[SLOT_W-1:0];
               state_in = S_EXEC;
            end else begin
               if (!idle_ok_ff && !slot_rd_ff.running) begin
                  idle_ok_in = 1'b1;
                  idle_in    = idx_ff[SLOT_W-1:0];
               end
               if (idx_ff == top_ext) begin
                  state_in = S_EXEC;
                  if (idle_ok_ff || !slot_rd_ff.running) begin
                     sel_in = (idle_ok_ff) ? idle_ff : idx_ff[SLOT_W-1:0];
                     own_in = 1'b1;
                  end else if (idx_ff < (SLOT_W+1)'(SLOTS_PER_REGION - 1)) begin
                     sel_in  = SLOT_W'(idx_ff + 1'b1);
                     own_in  = 1'b1;
                     open_in = 1'b1;
                  end else begin
                     sel_in  = '0;
                     full_in = 1'b1;
                  end
               end
            end
            idx_in = idx_ff + 1'b1;
            if (state_in == S_EXEC) idx_in = {1'b0, sel_in};
            slot_addr = {region_ff, idx_in[SLOT_W-1:0]};
         end
         S_EXEC: begin
            // slot_rd_ff holds the selected slot (if any)
            slot_addr = {region_ff, sel_ff};
            slot_wd   = slot_rd_ff;
            if (open_ff) slot_wd.running = 1'b0;
            if (own_ff) slot_wd.owner = tid_ff;
            if (open_ff) row_in.highest = sel_ff;
            if (mode_ff == MODE_START) begin
               row_in.starts = row_ff.starts + 32'd1;
               if (slot_wd.running) begin
                  row_in.error = 1'b1;
                  status_in = ST_START_RUN;
               end
               slot_wd.running    = 1'b1;
               slot_wd.start_time = ts_ff;
               slot_we = 1'b1;
            end else if (mode_ff == MODE_STOP) begin
               slot_we = 1'b1;
               if (slot_wd.running) begin
                  dur_in = diff;
                  row_in.total = row_ff.total + diff;
                  if (diff > row_ff.longest) row_in.longest = diff;
                  if (diff < row_ff.shortest || row_ff.stops == 32'd0)
                     row_in.shortest = diff;
                  row_in.stops = row_ff.stops + 32'd1;
                  slot_wd.running = 1'b0;
               end else begin
                  row_in.error = 1'b1;
                  status_in = ST_STOP_IDLE;
               end
            end
            if (status_in == ST_OK && full_ff) status_in = ST_FULL;
            region_we = 1'b1;
            region_wd = row_in;
            dreq.go       = 1'b1;
            dreq.dividend = row_in.total;
            dreq.divisor  = row_in.stops;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (drsp.done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, row_ff.error, drsp.quotient, row_ff.longest,
                               row_ff.shortest, row_ff.total, row_ff.stops,
                               row_ff.starts, dur_ff, sel_ff, status_ff};
               state_in = S_IDLE;
            end
         end
         S_WAIT: begin
            // A rejected region only loads the result once the register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {397'd0, ST_BAD_REG};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   logic [63:0] quot_hold_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         mode_ff   <= req_tdata[1:0];
         region_ff <= req_tdata[10:2];
         tid_ff    <= req_tdata[26:11];
         ts_ff     <= req_tdata[90:27];
      end
      idx_ff      <= idx_in;
      idle_ff     <= idle_in;
      idle_ok_ff  <= idle_ok_in;
      sel_ff      <= sel_in;
      own_ff      <= own_in;
      full_ff     <= full_in;
      open_ff     <= open_in;
      row_ff      <= row_in;
      status_ff   <= status_in;
      dur_ff      <= dur_in;
      rsp_data_ff <= rsp_data_in;
      quot_hold_ff <= drsp.quotient;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The divider result is only used once it reports done.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> $stable(quot_hold_ff) || $past(drsp.done))
      else $error("divider result changed before use");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !req_tready)
      else $error("item accepted during division");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
      else $error("result dropped while stalled");

endmodule

### tb/pcip_checker.sv
// Checker for the per-context interval profiler: watches the event and result streams,
// keeps its own profile tables and compares every result item. Depends on pcip_pkg.
module pcip_checker
   import pcip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [95:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [399:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending_count,
   output int           results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] owner_tab [NUM_REGIONS][SLOTS_PER_REGION];
   logic        running_tab [NUM_REGIONS][SLOTS_PER_REGION];
   logic [63:0] start_tab [NUM_REGIONS][SLOTS_PER_REGION];
   logic [5:0]  top_tab [NUM_REGIONS];
   logic [31:0] starts_tab [NUM_REGIONS];
   logic [31:0] stops_tab [NUM_REGIONS];
   logic [63:0] sum_tab [NUM_REGIONS];
   logic [63:0] min_tab [NUM_REGIONS];
   logic [63:0] max_tab [NUM_REGIONS];
   logic        err_tab [NUM_REGIONS];
   logic [9:0]  regions_limit;
   logic [399:0] expected_results [$];

   assign pending_count = expected_results.size();

   function automatic logic [399:0] profile_event(logic [95:0] ev);
      logic [1:0]  mode;
      int          r, s, idle, top;
      logic [15:0] tid;
      logic [63:0] ts, dur, avg;
      logic [2:0]  status;
      logic        full, found;
      mode = ev[1:0];
      r = ev[10:2];
      tid = ev[26:11];
      ts = ev[90:27];
      status = ST_OK;
      dur = '0;
      s = 0;
      full = 1'b0;
      if (r >= regions_limit) return {397'd0, ST_BAD_REG};
      if (mode == MODE_START || mode == MODE_STOP) begin
         top = top_tab[r];
         idle = -1;
         found = 1'b0;
         for (int i = 0; i <= top && !found; i++) begin
            if (owner_tab[r][i] == tid) begin
               s = i;
               found = 1'b1;
            end else if (idle < 0 && !running_tab[r][i]) idle = i;
         end
         if (!found) begin
            if (idle >= 0) begin
               s = idle;
               owner_tab[r][s] = tid;
            end else if (top + 1 < SLOTS_PER_REGION) begin
               s = top + 1;
               top_tab[r] = s;
               running_tab[r][s] = 1'b0;
               owner_tab[r][s] = tid;
            end else begin
               s = 0;
               full = 1'b1;
            end
         end
         if (mode == MODE_START) begin
            starts_tab[r]++;
            if (running_tab[r][s]) begin
               err_tab[r] = 1'b1;
               status = ST_START_RUN;
            end else running_tab[r][s] = 1'b1;
            start_tab[r][s] = ts;
         end else if (running_tab[r][s]) begin
            dur = ts - start_tab[r][s];
            sum_tab[r] += dur;
            if (dur > max_tab[r]) max_tab[r] = dur;
            if (dur < min_tab[r] || stops_tab[r] == 0) min_tab[r] = dur;
            stops_tab[r]++;
            running_tab[r][s] = 1'b0;
         end else begin
            err_tab[r] = 1'b1;
            status = ST_STOP_IDLE;
         end
      end
      if (status == ST_OK && full) status = ST_FULL;
      avg = (stops_tab[r] != 0) ? sum_tab[r] / {32'd0, stops_tab[r]} : 64'd0;
      return {7'd0, err_tab[r], avg, max_tab[r], min_tab[r], sum_tab[r],
              stops_tab[r], starts_tab[r], dur, s[4:0], status};
   endfunction

   task automatic report(string field, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at result %0d, %s: expected %0h, got %0h",
                  results_seen, field, want, got);
   endtask

   always @(posedge clock) begin
      logic [399:0] want;
      if (reset) begin
         for (int r = 0; r < NUM_REGIONS; r++) begin
            for (int s = 0; s < SLOTS_PER_REGION; s++) begin
               owner_tab[r][s] = '0;
               running_tab[r][s] = 1'b0;
               start_tab[r][s] = '0;
            end
            top_tab[r] = '0; starts_tab[r] = '0; stops_tab[r] = '0;
            sum_tab[r] = '0; min_tab[r] = '0; max_tab[r] = '0; err_tab[r] = 1'b0;
         end
         regions_limit = '0;
         fail_count = 0;
         results_seen = 0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == {REG_REGIONS, 2'b00})
            regions_limit = csr_pwdata[9:0];
         if (req_tvalid && req_tready)
            expected_results.push_back(profile_event(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report("unexpected result", '0, rsp_tdata[63:0]);
            end else begin
               want = expected_results.pop_front();
               if (want[2:0] != rsp_tdata[2:0]) report("status", want[2:0], rsp_tdata[2:0]);
               if (want[7:3] != rsp_tdata[7:3]) report("slot", want[7:3], rsp_tdata[7:3]);
               if (want[71:8] != rsp_tdata[71:8])
                  report("duration", want[71:8], rsp_tdata[71:8]);
               if (want[103:72] != rsp_tdata[103:72])
                  report("starts_seen", want[103:72], rsp_tdata[103:72]);
               if (want[135:104] != rsp_tdata[135:104])
                  report("stops_done", want[135:104], rsp_tdata[135:104]);
               if (want[199:136] != rsp_tdata[199:136])
                  report("total_time", want[199:136], rsp_tdata[199:136]);
               if (want[263:200] != rsp_tdata[263:200])
                  report("shortest", want[263:200], rsp_tdata[263:200]);
               if (want[327:264] != rsp_tdata[327:264])
                  report("longest", want[327:264], rsp_tdata[327:264]);
               if (want[391:328] != rsp_tdata[391:328])
                  report("average", want[391:328], rsp_tdata[391:328]);
               if (want[392] != rsp_tdata[392])
                  report("error_seen", want[392], rsp_tdata[392]);
            end
            results_seen++;
         end
      end
   end
endmodule

### tb/per_context_interval_profiler_tb.sv
// Top of the profiler testbench: clock, reset, register writes and event stimulus.
// Depends on pcip_pkg, pcip_checker and the per_context_interval_profiler RTL.
module per_context_interval_profiler_tb;
   import pcip_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 1500000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // [1:0] mode, [10:2] region_id, [26:11] thread_id, [90:27] timestamp
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [2:0] status, [7:3] slot, [71:8] duration, [103:72] starts_seen,
   // [135:104] stops_done, [199:136] total_time, [263:200] shortest,
   // [327:264] longest, [391:328] average, [392] error_seen
   logic [399:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count, pending_count, results_seen;
   int           cycle_count = 0;
   int           items_sent = 0;
   bit           hold_off = 1'b0;
   // Running clock, shared by all regions, used to build plausible timestamps.
   logic [63:0]  now_us = 64'd1000;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   per_context_interval_profiler uut (.*);

   pcip_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .fail_count, .pending_count, .results_seen);

   // Watchdog: the clearing pass after reset, the events, long receiver stalls and
   // sender gaps fit well below this bound.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Gap lengths: mostly zero or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // The receiver stalls at random, except during the long hold-off, when it refuses
   // everything so that the result register fills and the input backs up.
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic write_regions(logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_REGIONS, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one event item and holds it until the block takes it. A random gap
   // precedes it unless the caller asks for back-to-back items.
   task automatic send_event(logic [1:0] mode, logic [8:0] region, logic [15:0] tid,
                             logic [63:0] ts, bit no_gap);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, ts, tid, region, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      // The divider and write-back are done before the last result is offered; the wait only spaces the phases.
      repeat (120) @(posedge clock);
   endtask

   // Random traffic: well-paired start and stop on few regions and threads,
   // with reads, bare stops, double starts, bad regions and odd timestamps mixed in.
   task automatic random_phase(int count, int region_span, int thread_span);
      int          roll;
      logic [1:0]  mode;
      logic [8:0]  region;
      logic [15:0] tid;
      logic [63:0] ts;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         region = $urandom_range(0, region_span);
         tid = (roll < 5) ? 16'($urandom()) : 16'($urandom_range(0, thread_span));
         now_us += $urandom_range(0, 500);
         ts = now_us;
         if (roll < 3) ts = {$urandom(), $urandom()};
         if (roll < 40) mode = MODE_START;
         else if (roll < 85) mode = MODE_STOP;
         else if (roll < 95) mode = MODE_READ;
         else mode = MODE_SPARE;
         if (roll >= 97) region = 9'($urandom_range(0, 511));
         send_event(mode, region, tid, ts, 1'b0);
         // A well-formed pair: a start now, its stop shortly after.
         if (mode == MODE_START && roll < 30) begin
            now_us += $urandom_range(1, 2000);
            send_event(MODE_STOP, region, tid, now_us, 1'b0);
            n++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With no region registered every event is rejected.
      send_event(MODE_START, 9'd0, 16'd1, 64'd5, 1'b0);
      send_event(MODE_READ, 9'd511, 16'hFFFF, '1, 1'b0);
      drain();

      write_regions(32'd4);
      // Thread 0 already owns slot 0; a full-range wrap of the timestamp.
      send_event(MODE_START, 9'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
      send_event(MODE_STOP, 9'd0, 16'd0, 64'h0000_0000_0000_0010, 1'b0);
      // Stop without start, then start while running, then a good stop.
      send_event(MODE_STOP, 9'd1, 16'hFFFF, 64'd100, 1'b0);
      send_event(MODE_START, 9'd1, 16'hFFFF, 64'd200, 1'b0);
      send_event(MODE_START, 9'd1, 16'hFFFF, 64'd300, 1'b0);
      send_event(MODE_STOP, 9'd1, 16'hFFFF, '1, 1'b0);
      send_event(MODE_READ, 9'd1, 16'd0, '0, 1'b0);
      send_event(MODE_SPARE, 9'd0, 16'h5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
      // Just past the registered range.
      send_event(MODE_START, 9'd4, 16'd7, 64'd1, 1'b0);
      send_event(MODE_START, 9'd3, 16'd7, 64'd1, 1'b0);
      send_event(MODE_STOP, 9'd3, 16'd7, 64'd1, 1'b0);
      drain();

      // Fill every slot of region 2 with running threads, overflow onto slot 0,
      // then let an idle slot be reclaimed by a new thread.
      for (int t = 1; t <= SLOTS_PER_REGION + 1; t++) begin
         send_event(MODE_START, 9'd2, 16'(t * 97), 64'(t), 1'b1);
      end
      send_event(MODE_STOP, 9'd2, 16'(5 * 97), 64'd900, 1'b0);
      send_event(MODE_START, 9'd2, 16'hBEEF, 64'd950, 1'b0);
      drain();

      // Every region registered, with a long receiver hold-off while the
      // sender keeps offering items.
      write_regions(32'd512);
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         random_phase(12, 511, 3);
      join
      random_phase(140, 7, 5);
      drain();

      write_regions(32'd1);
      random_phase(80, 1, 3);
      drain();

      // A value above the number of regions still admits every region id.
      write_regions(32'd1023);
      random_phase(160, 15, 40);
      drain();

      write_regions(32'd0);
      send_event(MODE_READ, 9'd0, 16'd0, '0, 1'b0);
      drain();

      $display("covered %0d events and %0d results over six register settings,", items_sent,
               results_seen);
      $display("including slot overflow, unmatched starts and stops and timestamp wrap");
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

### per_context_interval_profiler.f
src/pcip_pkg.sv
src/pcip_divider.sv
src/per_context_interval_profiler.sv
tb/pcip_checker.sv
tb/per_context_interval_profiler_tb.sv
